// File: design/suffix_automaton_builder_top_assert.svh
// assertion macros for the suffix automaton builder
`ifndef SUFFIX_AUTOMATON_BUILDER_TOP_ASSERT_SVH
`define SUFFIX_AUTOMATON_BUILDER_TOP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SAB_ASSERT_IMPL(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// implication checked in the cycle after the antecedent
`define SAB_ASSERT_NEXT(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

// File: design/sab_pkg.sv
// package for the suffix automaton builder
`timescale 1ns / 1ps
package sab_pkg;
    localparam int MaxText  = 1024;
    localparam int Alphabet = 32;
    localparam int NStates  = 2 * MaxText;
    localparam int SW       = $clog2(NStates);
    localparam int AW       = $clog2(Alphabet);
    localparam int LW       = $clog2(MaxText + 1);
    localparam int TW       = SW + AW;

    localparam logic [1:0] ModeClear  = 2'd0;
    localparam logic [1:0] ModeAppend = 2'd1;
    localparam logic [1:0] ModeQuery  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] symbol;
        logic       last;
    } sab_in_t;

    typedef struct packed {
        logic found;
        logic overflow;
    } sab_out_t;
endpackage

// File: design/suffix_automaton_builder_top.sv
// suffix automaton builder: online append and substring query
//
//  channel | dir | ports
//  s_      | in  | s_valid s_ready s_data (mode symbol last)
//  m_      | out | m_valid m_ready m_data (found overflow)
//
// one beat at a time; a query symbol reads its transition in Q_RD and Q_WT
// append: allocate and clear the new row, then follow suffix links to the first
// state with a transition on the symbol; a clone copies the row and redirects links
// to the clone (each memory has one read and one write port), then A_FIN finishes
// clear marks the root row unwritten through 32 valid bits; reset does the same
// a pending result holds s_ready low until m_ready takes it
`timescale 1ns / 1ps
`include "suffix_automaton_builder_top_assert.svh"
module suffix_automaton_builder_top import sab_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sab_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sab_out_t m_data
);
    typedef enum logic [4:0] {
        IDLE, Q_RD, Q_WT, A_LEN, A_LENW, A_CLR, A_PRD, A_PWT, A_LINK, A_LINKW,
        A_QLEN, A_QLENW, A_CPR, A_CPW, A_CPWR, A_QLNK, A_QLNKW, A_RRD, A_RWT,
        A_RLINK, A_RLINKW, A_FIN
    } st_t;

    logic [SW-1:0] tt_mem [NStates*Alphabet];
    logic [SW-1:0] len_mem [NStates];
    logic [SW:0]   lnk_mem [NStates];
    logic [SW-1:0] tt_q, len_q;
    logic [SW:0]   lnk_q;
    logic          len_root_reg, lnk_root_reg;

    logic          tt_we, len_we, lnk_we;
    logic [TW-1:0] tt_wa, tt_ra;
    logic [SW-1:0] tt_wd, len_wa, len_ra, len_wd, lnk_wa, lnk_ra;
    logic [SW:0]   lnk_wd;

    always_ff @(posedge aclk) begin
        if (tt_we) tt_mem[tt_wa] <= tt_wd;
        tt_q <= tt_mem[tt_ra];
        if (len_we) len_mem[len_wa] <= len_wd;
        len_q <= len_mem[len_ra];
        len_root_reg <= (len_ra == '0);
        if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
        lnk_q <= lnk_mem[lnk_ra];
        lnk_root_reg <= (lnk_ra == '0);
    end

    // the root is never written: length zero, no suffix link
    logic [SW-1:0] len_val;
    logic [SW:0]   lnk_val;
    assign len_val = len_root_reg ? '0 : len_q;
    assign lnk_val = lnk_root_reg ? {1'b1, {SW{1'b0}}} : lnk_q;

    st_t            st_reg;
    logic [SW:0]    used_reg;
    logic [SW-1:0]  last_reg, cur_reg, cursor_reg, q_reg, cl_reg, plen_reg;
    logic [SW:0]    p_reg;
    logic [LW-1:0]  tlen_reg;
    logic           fail_reg, ovf_reg, m_valid_reg, clone_reg;
    logic [AW-1:0]  c_reg, k_reg;
    logic [Alphabet-1:0] root_ok_reg;
    sab_out_t       m_data_reg;

    // root row entries read as zero until written after a clear
    logic [SW-1:0] tt_val;
    assign tt_val = (tt_ra[TW-1:AW] == '0 && !root_ok_reg[tt_ra[AW-1:0]]) ? '0 : tt_q;
    logic [TW-1:0] tt_ra_reg;

    assign s_ready = (st_reg == IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    logic [SW-1:0] pidx;
    assign pidx = p_reg[SW-1:0];

    always_comb begin
        tt_we = 1'b0; tt_wa = '0; tt_wd = '0; tt_ra = tt_ra_reg;
        len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = '0;
        lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_ra = '0;
        case (st_reg)
            IDLE: tt_ra = {cursor_reg, s_data.symbol[AW-1:0]};
            A_LEN: len_ra = last_reg;
            A_LENW: begin
                len_we = 1'b1; len_wa = cur_reg; len_wd = len_val + 1'b1;
            end
            A_CLR: begin
                tt_we = 1'b1; tt_wa = {cur_reg, k_reg};
            end
            A_PRD: begin
                tt_ra = {pidx, c_reg}; len_ra = pidx;
            end
            A_LINK: begin
                tt_we = 1'b1; tt_wa = {pidx, c_reg}; tt_wd = cur_reg; lnk_ra = pidx;
            end
            A_QLEN: len_ra = q_reg;
            A_QLENW: begin
                len_we = (plen_reg + 1'b1) != len_val; len_wa = used_reg[SW-1:0];
                len_wd = plen_reg + 1'b1;
            end
            A_CPR: tt_ra = {q_reg, k_reg};
            A_CPWR: begin
                tt_we = 1'b1; tt_wa = {cl_reg, k_reg}; tt_wd = tt_val;
                lnk_ra = q_reg;
            end
            A_QLNK: begin
                lnk_we = 1'b1; lnk_wa = cl_reg; lnk_wd = lnk_val;
            end
            // q is never on the walked chain, so its link can turn to the clone here
            A_RRD: begin
                tt_ra = {pidx, c_reg};
                lnk_we = 1'b1; lnk_wa = q_reg; lnk_wd = {1'b0, cl_reg};
            end
            A_RLINK: begin
                tt_we = 1'b1; tt_wa = {pidx, c_reg}; tt_wd = cl_reg; lnk_ra = pidx;
            end
            A_FIN: begin
                lnk_we = 1'b1; lnk_wa = cur_reg;
                lnk_wd = {1'b0, clone_reg ? cl_reg : q_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= IDLE; used_reg <= (SW+1)'(1); last_reg <= '0; tlen_reg <= '0;
            cursor_reg <= '0; fail_reg <= 1'b0; ovf_reg <= 1'b0; m_valid_reg <= 1'b0;
            root_ok_reg <= '0; tt_ra_reg <= '0;
        end else begin
            tt_ra_reg <= tt_ra;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (tt_we && tt_wa[TW-1:AW] == '0) root_ok_reg[tt_wa[AW-1:0]] <= 1'b1;
            case (st_reg)
                IDLE: if (s_valid && s_ready) begin
                    c_reg <= s_data.symbol[AW-1:0];
                    case (s_data.mode)
                        ModeClear: begin
                            used_reg <= (SW+1)'(1); last_reg <= '0; tlen_reg <= '0;
                            cursor_reg <= '0; fail_reg <= 1'b0; ovf_reg <= 1'b0;
                            root_ok_reg <= '0;
                        end
                        ModeAppend: begin
                            if (tlen_reg == LW'(MaxText)) ovf_reg <= 1'b1;
                            else begin
                                cur_reg <= used_reg[SW-1:0];
                                used_reg <= used_reg + 1'b1;
                                k_reg <= '0; clone_reg <= 1'b0;
                                p_reg <= {1'b0, last_reg};
                                st_reg <= A_LEN;
                            end
                        end
                        ModeQuery: begin
                            clone_reg <= s_data.last;
                            st_reg <= Q_RD;
                        end
                        default: ;
                    endcase
                end
                Q_RD: st_reg <= Q_WT;
                Q_WT: begin
                    if (clone_reg) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.found <= !fail_reg && tt_val != '0;
                        m_data_reg.overflow <= ovf_reg;
                        cursor_reg <= '0; fail_reg <= 1'b0;
                    end else if (!fail_reg) begin
                        if (tt_val == '0) fail_reg <= 1'b1;
                        else cursor_reg <= tt_val;
                    end
                    clone_reg <= 1'b0;
                    st_reg <= IDLE;
                end
                A_LEN: st_reg <= A_LENW;
                A_LENW: st_reg <= A_CLR;
                A_CLR: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == AW'(Alphabet - 1)) st_reg <= A_PRD;
                end
                A_PRD: st_reg <= A_PWT;
                A_PWT: begin
                    plen_reg <= len_val;
                    if (tt_val == '0) st_reg <= A_LINK;
                    else begin
                        q_reg <= tt_val;
                        st_reg <= A_QLEN;
                    end
                end
                A_LINK: st_reg <= A_LINKW;
                A_LINKW: begin
                    p_reg <= lnk_val;
                    if (lnk_val[SW]) begin
                        q_reg <= '0; st_reg <= A_FIN;
                    end else st_reg <= A_PRD;
                end
                A_QLEN: st_reg <= A_QLENW;
                A_QLENW: begin
                    if ((plen_reg + 1'b1) == len_val) st_reg <= A_FIN;
                    else begin
                        cl_reg <= used_reg[SW-1:0];
                        used_reg <= used_reg + 1'b1;
                        clone_reg <= 1'b1; k_reg <= '0;
                        st_reg <= A_CPR;
                    end
                end
                A_CPR: st_reg <= A_CPW;
                A_CPW: st_reg <= A_CPWR;
                A_CPWR: begin
                    k_reg <= k_reg + 1'b1;
                    st_reg <= (k_reg == AW'(Alphabet - 1)) ? A_QLNK : A_CPR;
                end
                A_QLNK: st_reg <= A_RRD;
                A_RRD: st_reg <= A_RWT;
                A_RWT: st_reg <= (tt_val == q_reg) ? A_RLINK : A_FIN;
                A_RLINK: st_reg <= A_RLINKW;
                A_RLINKW: begin
                    p_reg <= lnk_val;
                    st_reg <= lnk_val[SW] ? A_FIN : A_RRD;
                end
                A_FIN: begin
                    last_reg <= cur_reg; tlen_reg <= tlen_reg + 1'b1;
                    st_reg <= IDLE;
                end
                default: st_reg <= IDLE;
            endcase
        end
    end

    `SAB_ASSERT_IMPL(a_busy_no_ready, aclk, aresetn, st_reg != IDLE, !s_ready, "ready while busy")
    `SAB_ASSERT_IMPL(a_used_bound, aclk, aresetn, 1'b1, used_reg <= (SW+1)'(NStates), "state overrun")
    `SAB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped")
endmodule
